// ===== design/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants of the bracketed Latin text classifier: the
// channel payloads, the UTF-8 decoder state and the code point limits.
// ----------------------------------------------------------------------------
package btc_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic framing_ok;
        logic is_annotation;
    } out_item_t;

    typedef struct packed {
        logic [15:0] code_accum;
        logic [1:0]  bytes_pending;
        logic [1:0]  sequence_length;
        logic        body_fail;
        logic        seen_letter;
    } dec_state_t;

    // Opening and closing bracket markers (fullwidth brackets in UTF-8).
    localparam logic [7:0] OPEN_0  = 8'hEF;
    localparam logic [7:0] OPEN_1  = 8'hBC;
    localparam logic [7:0] OPEN_2  = 8'hBB;
    localparam logic [7:0] CLOSE_0 = 8'hEF;
    localparam logic [7:0] CLOSE_1 = 8'hBC;
    localparam logic [7:0] CLOSE_2 = 8'hBD;

    // Encoded sequence lengths.
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // Smallest code points that need two or three bytes.
    localparam logic [15:0] MIN_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;

    localparam logic [15:0] SURROGATE_LO = 16'hD800;
    localparam logic [15:0] SURROGATE_HI = 16'hDFFF;
    localparam logic [15:0] COMBINING_LO = 16'h0300;
    localparam logic [15:0] COMBINING_HI = 16'h036F;
    localparam logic [15:0] LATIN_LO     = 16'h00C0;
    localparam logic [15:0] LATIN_HI     = 16'h017F;
    localparam logic [15:0] TIMES_SIGN   = 16'h00D7;
    localparam logic [15:0] DIVIDE_SIGN  = 16'h00F7;
    localparam logic [15:0] LATIN_ADD_LO = 16'h1E00;
    localparam logic [15:0] LATIN_ADD_HI = 16'h1EFF;

    localparam logic [15:0] UPPER_A    = 16'h0041;
    localparam logic [15:0] UPPER_Z    = 16'h005A;
    localparam logic [15:0] LOWER_A    = 16'h0061;
    localparam logic [15:0] LOWER_Z    = 16'h007A;
    localparam logic [15:0] CHAR_SPACE = 16'h0020;
    localparam logic [15:0] CHAR_APOS  = 16'h0027;
    localparam logic [15:0] CHAR_DASH  = 16'h002D;
    localparam logic [15:0] CHAR_COLON = 16'h003A;
    localparam logic [15:0] DIGIT_ZERO = 16'h0030;
    localparam logic [15:0] DIGIT_FIVE = 16'h0035;

    localparam logic [2:0] COUNT_MAX       = 3'd7;
    localparam logic [2:0] BODY_START      = 3'd6;
    localparam logic [2:0] OPEN_MARK_BYTES = 3'd3;

endpackage

// ===== design/btc_decode.sv =====
// ----------------------------------------------------------------------------
// btc_decode
// One body byte through the UTF-8 decoder: accumulates multi-byte
// characters and classifies each finished character.
// ----------------------------------------------------------------------------
module btc_decode (
    input  logic                  en,
    input  logic [7:0]            byte_value,
    input  btc_pkg::dec_state_t   cur,
    output btc_pkg::dec_state_t   nxt
);

    // Returns {fail, letter} for one finished character.
    function automatic logic [1:0] check_char(input logic [15:0] c, input logic [1:0] len);
        logic bad_form;
        logic letter;
        logic mark;
        logic sep;
        bad_form = (len == btc_pkg::LEN_TWO && c < btc_pkg::MIN_TWO_BYTE) ||
                   (len == btc_pkg::LEN_THREE && c < btc_pkg::MIN_THREE_BYTE) ||
                   (c >= btc_pkg::SURROGATE_LO && c <= btc_pkg::SURROGATE_HI);
        letter = (c >= btc_pkg::UPPER_A && c <= btc_pkg::UPPER_Z) ||
                 (c >= btc_pkg::LOWER_A && c <= btc_pkg::LOWER_Z) ||
                 (c >= btc_pkg::LATIN_LO && c <= btc_pkg::LATIN_HI &&
                  c != btc_pkg::TIMES_SIGN && c != btc_pkg::DIVIDE_SIGN) ||
                 (c >= btc_pkg::LATIN_ADD_LO && c <= btc_pkg::LATIN_ADD_HI);
        mark = c >= btc_pkg::COMBINING_LO && c <= btc_pkg::COMBINING_HI;
        sep = c == btc_pkg::CHAR_SPACE || c == btc_pkg::CHAR_APOS ||
              c == btc_pkg::CHAR_DASH || c == btc_pkg::CHAR_COLON ||
              (c >= btc_pkg::DIGIT_ZERO && c <= btc_pkg::DIGIT_FIVE);
        if (bad_form)
        begin
            return 2'b10;
        end
        return {!(letter || mark || sep), letter};
    endfunction

    logic [15:0] cont_accum;
    logic [1:0]  chk_ascii;
    logic [1:0]  chk_multi;

    assign cont_accum = {cur.code_accum[9:0], byte_value[5:0]};
    assign chk_ascii  = check_char({8'd0, byte_value}, btc_pkg::LEN_ONE);
    assign chk_multi  = check_char(cont_accum, cur.sequence_length);

    always_comb
    begin
        nxt = cur;
        if (en)
        begin
            if (cur.bytes_pending == 2'd0)
            begin
                if (!byte_value[7])
                begin
                    nxt.body_fail   = cur.body_fail | chk_ascii[1];
                    nxt.seen_letter = cur.seen_letter | chk_ascii[0];
                end
                else if (byte_value[7:5] == 3'b110)
                begin
                    nxt.code_accum      = {11'd0, byte_value[4:0]};
                    nxt.bytes_pending   = 2'd1;
                    nxt.sequence_length = btc_pkg::LEN_TWO;
                end
                else if (byte_value[7:4] == 4'b1110)
                begin
                    nxt.code_accum      = {12'd0, byte_value[3:0]};
                    nxt.bytes_pending   = 2'd2;
                    nxt.sequence_length = btc_pkg::LEN_THREE;
                end
                else
                begin
                    nxt.body_fail = 1'b1;
                end
            end
            else if (byte_value[7:6] != 2'b10)
            begin
                nxt.body_fail     = 1'b1;
                nxt.bytes_pending = 2'd0;
            end
            else
            begin
                nxt.code_accum    = cont_accum;
                nxt.bytes_pending = cur.bytes_pending - 2'd1;
                if (cur.bytes_pending == 2'd1)
                begin
                    nxt.body_fail   = cur.body_fail | chk_multi[1];
                    nxt.seen_letter = cur.seen_letter | chk_multi[0];
                end
            end
        end
    end

endmodule

// ===== design/bracketed_latin_text_classifier.sv =====
// ----------------------------------------------------------------------------
// bracketed_latin_text_classifier
// Classifies a bracketed comment string, fed one byte per transaction, as
// framed and as valid Latin pronunciation text.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_data) carries one byte of
//   the comment per transaction, with last set on the final byte. The result
//   channel (result_valid, result_stall, result_data) carries one
//   transaction per comment, issued only for the final byte.
//   Each byte is captured in an input register; from there the decode and
//   classification logic updates the running state and, for a final byte,
//   loads the result register. One byte is taken every cycle unless
//   byte_stall is raised by a waiting final byte.
//   After a result is produced, all running state returns to its reset value
//   so the next comment starts clean.
//   When the receiver stalls, the result register holds; non-final bytes
//   keep flowing, and a final byte waits in the input register, with
//   byte_stall raised, until the result register is free.
//   Reset clears the valid flags and running state; no result is pending afterward.
// ----------------------------------------------------------------------------
module bracketed_latin_text_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  btc_pkg::in_item_t  byte_data,
    output logic               result_valid,
    input  logic               result_stall,
    output btc_pkg::out_item_t result_data
);

    logic                s1_valid_reg;
    btc_pkg::in_item_t   s1_item_reg;
    logic [7:0]          recent_reg [3];
    logic [7:0]          recent_next [3];
    logic [2:0]          count_reg;
    logic [2:0]          count_next;
    logic                prefix_bad_reg;
    logic                prefix_bad_next;
    btc_pkg::dec_state_t dec_reg;
    btc_pkg::dec_state_t dec_step;
    btc_pkg::dec_state_t dec_next;
    logic                out_valid_reg;
    btc_pkg::out_item_t  out_item_reg;
    btc_pkg::out_item_t  out_item_next;

    logic       out_free;
    logic       s1_fire;
    logic       body_en;
    logic [7:0] open_byte;
    logic       framed;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign byte_stall = s1_valid_reg && !s1_fire;
    assign body_en    = count_reg >= btc_pkg::BODY_START;

    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    open_byte = btc_pkg::OPEN_0;
            2'd1:    open_byte = btc_pkg::OPEN_1;
            default: open_byte = btc_pkg::OPEN_2;
        endcase
    end

    btc_decode u_decode (
        .en         (body_en),
        .byte_value (recent_reg[0]),
        .cur        (dec_reg),
        .nxt        (dec_step)
    );

    always_comb
    begin
        prefix_bad_next = prefix_bad_reg ||
                          (count_reg < btc_pkg::OPEN_MARK_BYTES &&
                           s1_item_reg.byte_value != open_byte);

        framed = (count_reg >= btc_pkg::BODY_START) && !prefix_bad_next &&
                 recent_reg[1] == btc_pkg::CLOSE_0 &&
                 recent_reg[2] == btc_pkg::CLOSE_1 &&
                 s1_item_reg.byte_value == btc_pkg::CLOSE_2;
        out_item_next.framing_ok    = framed;
        out_item_next.is_annotation = framed && !dec_step.body_fail &&
                                      dec_step.bytes_pending == 2'd0 &&
                                      dec_step.seen_letter;

        // The final byte of a comment returns everything to its reset value.
        if (s1_item_reg.last)
        begin
            recent_next[0] = 8'd0;
            recent_next[1] = 8'd0;
            recent_next[2] = 8'd0;
            count_next     = 3'd0;
            dec_next       = '0;
        end
        else
        begin
            recent_next[0] = recent_reg[1];
            recent_next[1] = recent_reg[2];
            recent_next[2] = s1_item_reg.byte_value;
            count_next     = (count_reg == btc_pkg::COUNT_MAX) ? count_reg
                                                               : count_reg + 3'd1;
            dec_next       = dec_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            recent_reg[0]  <= 8'd0;
            recent_reg[1]  <= 8'd0;
            recent_reg[2]  <= 8'd0;
            count_reg      <= 3'd0;
            prefix_bad_reg <= 1'b0;
            dec_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                recent_reg     <= recent_next;
                count_reg      <= count_next;
                prefix_bad_reg <= prefix_bad_next && !s1_item_reg.last;
                dec_reg        <= dec_next;
            end

            if (s1_fire && s1_item_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            s1_item_reg <= byte_data;
        end
        if (s1_fire && s1_item_reg.last)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    // A new result only ever follows a final byte leaving the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_item_reg.last))
        else $error("result issued without a final byte");

    // Running state is clear after each comment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_item_reg.last) |=>
            (count_reg == 3'd0 && !prefix_bad_reg && dec_reg == '0))
        else $error("state not cleared after a comment");

    // An annotation is always framed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_item_reg.is_annotation || out_item_reg.framing_ok))
        else $error("annotation without framing");

    // The decoder never expects more than two continuation bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg.bytes_pending != 2'd3)
        else $error("bad continuation count");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives comment strings byte by byte into the bracketed Latin text
// classifier and checks every verdict against a cycle-free predictor or a
// typed table entry. A short table of hand-written comments comes first.
// Random comments follow: mostly bracketed bodies of valid and invalid
// UTF-8 characters, plus broken markers, short strings and noise. Four
// traffic phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BYTES = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0]         value;
        logic               last;
        logic               typed;
        btc_pkg::out_item_t want;
    } dir_row_t;

    localparam logic [7:0] OPEN_SEQ [3] = '{btc_pkg::OPEN_0, btc_pkg::OPEN_1,
                                            btc_pkg::OPEN_2};

    logic               clk;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    btc_pkg::in_item_t  byte_data = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    btc_pkg::out_item_t result_data;

    // Predictor state.
    logic [7:0]  tail_bytes [3] = '{8'h00, 8'h00, 8'h00};
    logic [2:0]  seen_count = '0;
    logic        open_mismatch = 1'b0;
    logic        utf_bad = 1'b0;
    logic        got_letter = 1'b0;
    logic [15:0] partial_cp = '0;
    logic [1:0]  cont_left = '0;
    logic [1:0]  char_len = '0;

    btc_pkg::out_item_t verdicts [$];
    logic [7:0]  text [$];
    int          send_idle = 0;
    int          recv_stall = 0;
    int          errors = 0;
    int          bytes_sent = 0;
    int          comments = 0;
    int          checked = 0;
    int          framed_seen = 0;
    int          annot_seen = 0;

    // Short comment with extreme bytes, a minimal annotation, a truncated
    // character, a bad lead byte and a bad continuation byte.
    dir_row_t directed_rows [31] = '{
        '{8'h00, 1'b0, 1'b0, 2'b00}, '{8'hFF, 1'b1, 1'b1, 2'b00},
        '{btc_pkg::OPEN_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::OPEN_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::OPEN_2, 1'b0, 1'b0, 2'b00}, '{8'h61, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::CLOSE_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_2, 1'b1, 1'b1, 2'b11},
        '{btc_pkg::OPEN_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::OPEN_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::OPEN_2, 1'b0, 1'b0, 2'b00}, '{8'hC3, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::CLOSE_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_2, 1'b1, 1'b1, 2'b10},
        '{btc_pkg::OPEN_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::OPEN_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::OPEN_2, 1'b0, 1'b0, 2'b00}, '{8'hFF, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::CLOSE_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_2, 1'b1, 1'b1, 2'b10},
        '{btc_pkg::OPEN_0, 1'b0, 1'b0, 2'b00}, '{btc_pkg::OPEN_1, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::OPEN_2, 1'b0, 1'b0, 2'b00}, '{8'hC3, 1'b0, 1'b0, 2'b00},
        '{8'h41, 1'b0, 1'b0, 2'b00}, '{btc_pkg::CLOSE_0, 1'b0, 1'b0, 2'b00},
        '{btc_pkg::CLOSE_1, 1'b0, 1'b0, 2'b00}, '{btc_pkg::CLOSE_2, 1'b1, 1'b0, 2'b00}
    };

    bracketed_latin_text_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout: no completion within %0d cycles.", CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Judges one decoded code point of the body.
    function automatic void judge_codepoint(input logic [15:0] cp, input logic [1:0] len);
        logic letter;
        logic mark;
        logic sep;
        if ((len == btc_pkg::LEN_TWO && cp < btc_pkg::MIN_TWO_BYTE) ||
            (len == btc_pkg::LEN_THREE && cp < btc_pkg::MIN_THREE_BYTE))
        begin
            utf_bad = 1'b1;
            return;
        end
        if (cp >= btc_pkg::SURROGATE_LO && cp <= btc_pkg::SURROGATE_HI)
        begin
            utf_bad = 1'b1;
            return;
        end
        letter = (cp >= btc_pkg::UPPER_A && cp <= btc_pkg::UPPER_Z) ||
                 (cp >= btc_pkg::LOWER_A && cp <= btc_pkg::LOWER_Z) ||
                 (cp >= btc_pkg::LATIN_LO && cp <= btc_pkg::LATIN_HI &&
                  cp != btc_pkg::TIMES_SIGN && cp != btc_pkg::DIVIDE_SIGN) ||
                 (cp >= btc_pkg::LATIN_ADD_LO && cp <= btc_pkg::LATIN_ADD_HI);
        mark = cp >= btc_pkg::COMBINING_LO && cp <= btc_pkg::COMBINING_HI;
        sep = cp == btc_pkg::CHAR_SPACE || cp == btc_pkg::CHAR_APOS ||
              cp == btc_pkg::CHAR_DASH || cp == btc_pkg::CHAR_COLON ||
              (cp >= btc_pkg::DIGIT_ZERO && cp <= btc_pkg::DIGIT_FIVE);
        if (!letter && !mark && !sep)
            utf_bad = 1'b1;
        if (letter)
            got_letter = 1'b1;
    endfunction

    // Advances the predictor by one byte; returns 1 with the verdict on a final byte.
    function automatic bit classify_byte(input btc_pkg::in_item_t it,
                                         output btc_pkg::out_item_t res);
        logic [7:0] leaving;
        logic       framed;
        res = '0;
        leaving = tail_bytes[0];
        if (seen_count < btc_pkg::OPEN_MARK_BYTES &&
            it.byte_value != OPEN_SEQ[seen_count[1:0]])
            open_mismatch = 1'b1;
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = tail_bytes[2];
        tail_bytes[2] = it.byte_value;

        // The byte leaving the delay line is a body byte once the opening
        // marker and three held-back bytes have gone by.
        if (seen_count >= btc_pkg::BODY_START)
        begin
            if (cont_left == 2'd0)
            begin
                if (!leaving[7])
                    judge_codepoint({8'h00, leaving}, btc_pkg::LEN_ONE);
                else if (leaving[7:5] == 3'b110)
                begin
                    partial_cp = {11'd0, leaving[4:0]};
                    cont_left = 2'd1;
                    char_len = btc_pkg::LEN_TWO;
                end
                else if (leaving[7:4] == 4'b1110)
                begin
                    partial_cp = {12'd0, leaving[3:0]};
                    cont_left = 2'd2;
                    char_len = btc_pkg::LEN_THREE;
                end
                else
                    utf_bad = 1'b1;
            end
            else if (leaving[7:6] != 2'b10)
            begin
                utf_bad = 1'b1;
                cont_left = 2'd0;
            end
            else
            begin
                partial_cp = {partial_cp[9:0], leaving[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    judge_codepoint(partial_cp, char_len);
            end
        end

        if (seen_count < btc_pkg::COUNT_MAX)
            seen_count = seen_count + 3'd1;
        if (!it.last)
            return 1'b0;

        framed = seen_count == btc_pkg::COUNT_MAX && !open_mismatch &&
                 tail_bytes[0] == btc_pkg::CLOSE_0 &&
                 tail_bytes[1] == btc_pkg::CLOSE_1 &&
                 tail_bytes[2] == btc_pkg::CLOSE_2;
        res.framing_ok = framed;
        res.is_annotation = framed && !utf_bad && cont_left == 2'd0 && got_letter;

        tail_bytes = '{8'h00, 8'h00, 8'h00};
        seen_count = '0;
        open_mismatch = 1'b0;
        utf_bad = 1'b0;
        got_letter = 1'b0;
        partial_cp = '0;
        cont_left = '0;
        char_len = '0;
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] v, input logic fin, input bit typed,
                             input btc_pkg::out_item_t want);
        btc_pkg::in_item_t  it;
        btc_pkg::out_item_t res;
        it.byte_value = v;
        it.last = fin;
        while ($urandom_range(0, 99) < send_idle)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        if (classify_byte(it, res))
        begin
            comments++;
            verdicts.push_back(typed ? want : res);
        end
        @(negedge clk);
    endtask

    // Appends a code point encoded in the given number of bytes, overlong or not.
    task automatic add_char(input logic [15:0] cp, input logic [1:0] len);
        case (len)
            btc_pkg::LEN_ONE:   text.push_back(cp[7:0]);
            btc_pkg::LEN_TWO:
            begin
                text.push_back({3'b110, cp[10:6]});
                text.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text.push_back({4'b1110, cp[15:12]});
                text.push_back({2'b10, cp[11:6]});
                text.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_body_char(input bit valid_only);
        int          pick;
        logic [15:0] cp;
        pick = valid_only ? $urandom_range(0, 4) : $urandom_range(5, 13);
        case (pick)
            0:
            begin
                if ($urandom_range(0, 1) == 0)
                    cp = 16'($urandom_range(btc_pkg::UPPER_A, btc_pkg::UPPER_Z));
                else
                    cp = 16'($urandom_range(btc_pkg::LOWER_A, btc_pkg::LOWER_Z));
                add_char(cp, btc_pkg::LEN_ONE);
            end
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       cp = btc_pkg::CHAR_SPACE;
                    1:       cp = btc_pkg::CHAR_APOS;
                    2:       cp = btc_pkg::CHAR_DASH;
                    3:       cp = btc_pkg::CHAR_COLON;
                    default: cp = 16'($urandom_range(btc_pkg::DIGIT_ZERO,
                                                     btc_pkg::DIGIT_FIVE));
                endcase
                add_char(cp, btc_pkg::LEN_ONE);
            end
            2:  add_char(16'($urandom_range(btc_pkg::LATIN_LO, btc_pkg::LATIN_HI)),
                         btc_pkg::LEN_TWO);
            3:  add_char(16'($urandom_range(btc_pkg::COMBINING_LO, btc_pkg::COMBINING_HI)),
                         btc_pkg::LEN_TWO);
            4:  add_char(16'($urandom_range(btc_pkg::LATIN_ADD_LO, btc_pkg::LATIN_ADD_HI)),
                         btc_pkg::LEN_THREE);
            5:  add_char(16'($urandom_range(0, 127)), btc_pkg::LEN_ONE);
            6:  add_char(16'($urandom_range(0, btc_pkg::MIN_TWO_BYTE - 1)),
                         btc_pkg::LEN_TWO);
            7:  add_char(16'($urandom_range(0, btc_pkg::MIN_THREE_BYTE - 1)),
                         btc_pkg::LEN_THREE);
            8:  add_char(16'($urandom_range(btc_pkg::SURROGATE_LO, btc_pkg::SURROGATE_HI)),
                         btc_pkg::LEN_THREE);
            9:  add_char(16'($urandom_range(btc_pkg::MIN_THREE_BYTE, 16'hFFFF)),
                         btc_pkg::LEN_THREE);
            // A lead byte whose continuation never comes.
            10: text.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hDF))
                                                     : 8'($urandom_range(8'hE0, 8'hEF)));
            11: text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            12: text.push_back(8'($urandom_range(8'hF0, 8'hFF)));
            default: add_char($urandom_range(0, 1) ? btc_pkg::TIMES_SIGN
                                                   : btc_pkg::DIVIDE_SIGN,
                              btc_pkg::LEN_TWO);
        endcase
    endtask

    task automatic send_random_comment();
        int kind;
        int n;
        int idx;
        int pos;
        text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            text.push_back(btc_pkg::OPEN_0);
            text.push_back(btc_pkg::OPEN_1);
            text.push_back(btc_pkg::OPEN_2);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                add_body_char($urandom_range(0, 99) < 88);
            text.push_back(btc_pkg::CLOSE_0);
            text.push_back(btc_pkg::CLOSE_1);
            text.push_back(btc_pkg::CLOSE_2);
            if (kind >= 70)
            begin
                idx = $urandom_range(0, 5);
                pos = (idx < 3) ? idx : text.size() - 6 + idx;
                text[pos] = text[pos] ^ 8'($urandom_range(1, 255));
            end
        end
        else
        begin
            n = (kind < 88) ? $urandom_range(1, 6) : $urandom_range(1, 14);
            for (int i = 0; i < n; i++)
                text.push_back(8'($urandom_range(0, 255)));
            if (kind < 84)
                for (int i = 0; i < n && i < 3; i++)
                    text[i] = OPEN_SEQ[i];
        end
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1, 1'b0, '0);
    endtask

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < recv_stall);

    always @(posedge clk)
    begin
        btc_pkg::out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdicts.size() == 0)
            begin
                $error("Result transaction with no verdict pending: %b", result_data);
                errors++;
            end
            else
            begin
                want = verdicts.pop_front();
                checked++;
                if (want.framing_ok)
                    framed_seen++;
                if (want.is_annotation)
                    annot_seen++;
                if (result_data.framing_ok !== want.framing_ok)
                begin
                    $error("framing_ok: expected %0b, got %0b",
                           want.framing_ok, result_data.framing_ok);
                    errors++;
                end
                if (result_data.is_annotation !== want.is_annotation)
                begin
                    $error("is_annotation: expected %0b, got %0b",
                           want.is_annotation, result_data.is_annotation);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int send_rates [4];
        int stall_rates [4];
        send_rates = '{0, 67, 0, 6};
        stall_rates = '{0, 0, 67, 6};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = send_rates[phase];
            recv_stall = stall_rates[phase];
            while (bytes_sent < (phase + 1) * TOTAL_BYTES / 4)
                send_random_comment();
            // Let the block drain completely before the next phase starts.
            byte_valid <= 1'b0;
            @(negedge clk);
            while (verdicts.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d comments under four traffic phases.",
                 bytes_sent, comments);
        $display("Checked %0d verdicts: %0d framed, %0d annotations, %0d errors.",
                 checked, framed_seen, annot_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
